[hw/rtl/mast_pkg.sv]
// shared types and constants for the moving-average silence trimmer
// no dependencies; imported by mast_front, mast_window, mast_bounds and by the top level
`timescale 1ns / 1ps

package mast_pkg;

	// fixed field widths
	localparam int SAMPLE_BITS = 16;
	localparam int INDEX_BITS  = 24;
	localparam int MARGIN_W    = 24;
	localparam int STEPS_W     = 11;
	localparam int THR_W       = 15;

	// register reset values
	localparam int STEPS_RST = 256;
	localparam int THR_RST   = 328;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_MARGIN            = 2'd0,
		CFG_WINDOW_STEPS      = 2'd1,
		CFG_SILENCE_THRESHOLD = 2'd2
	} cfg_reg_e;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last_sample;
	} sample_word_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] start_index;
		logic [INDEX_BITS:0]   kept_length;
	} trim_word_t;

	// one sample on its way into the window stage
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] lvl;
		logic [INDEX_BITS-1:0]  idx;
		logic [INDEX_BITS-1:0]  start;
		logic [INDEX_BITS:0]    len;
		logic                   active;
		logic                   sub;
		logic                   full;
		logic                   last;
	} win_item_t;

	// raw clip bounds at end of clip
	typedef struct packed {
		logic [INDEX_BITS-1:0] lb;
		logic [INDEX_BITS-1:0] rb;
		logic [INDEX_BITS-1:0] len_m1;
	} bnd_item_t;

endpackage

[hw/rtl/mast_ram.sv]
// generic simple dual-port ram, one write and one registered read per cycle
// read-first on a same-address collision; no dependencies
`timescale 1ns / 1ps

module mast_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic             re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

[hw/rtl/mast_front.sv]
// input stage: level computation, sample counter, delay-line addressing
// depends on mast_pkg; drives the delay-line ram and the window stage
`timescale 1ns / 1ps

module mast_front
	import mast_pkg::*;
#(
	parameter int MAX_WINDOW = 1024,
	parameter int ADDR_W = 10,
	parameter int STEP_W = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   hold,
	input  sample_word_t           word,
	input  logic [STEP_W-1:0]      eff_steps,
	input  logic [THR_W-1:0]       threshold,
	output logic                   ram_we,
	output logic [ADDR_W-1:0]      ram_waddr,
	output logic [SAMPLE_BITS-1:0] ram_wdata,
	output logic                   ram_re,
	output logic [ADDR_W-1:0]      ram_raddr,
	output logic                   valid_s1,
	output win_item_t              item_s1
);

	logic [INDEX_BITS:0]    seen_q;
	logic [ADDR_W-1:0]      ptr_q;
	logic [ADDR_W-1:0]      ptr_nxt;
	logic                   active;
	logic [INDEX_BITS:0]    seen_nxt;
	logic [INDEX_BITS:0]    steps_x;
	logic                   sub;
	logic                   full;
	logic [STEP_W:0]        ptr_w;
	logic [STEP_W:0]        steps_w;
	logic [STEP_W:0]        old_pos;
	logic [SAMPLE_BITS-1:0] raw;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SAMPLE_BITS-1:0] thr_x;
	logic [SAMPLE_BITS-1:0] lvl;

	// level = max(0, |x| - threshold)
	always_comb begin
		raw   = word.sample;
		mag   = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
		thr_x = SAMPLE_BITS'(threshold);
		lvl   = (mag > thr_x) ? (mag - thr_x) : '0;
	end

	always_comb begin
		active   = !seen_q[INDEX_BITS];
		seen_nxt = active ? (seen_q + 1'b1) : seen_q;
		steps_x  = (INDEX_BITS + 1)'(eff_steps);
		sub      = active && (seen_q >= steps_x);
		full     = seen_nxt >= steps_x;
		ptr_nxt  = (ptr_q == ADDR_W'(MAX_WINDOW - 1)) ? '0 : (ptr_q + 1'b1);
		// entry written steps samples ago, modulo the ring depth
		ptr_w    = (STEP_W + 1)'(ptr_q);
		steps_w  = (STEP_W + 1)'(eff_steps);
		old_pos  = (ptr_w >= steps_w) ? (ptr_w - steps_w)
			: (ptr_w + (STEP_W + 1)'(MAX_WINDOW) - steps_w);
	end

	assign ram_we    = accept && active;
	assign ram_waddr = ptr_q;
	assign ram_wdata = lvl;
	assign ram_re    = accept && sub;
	assign ram_raddr = ADDR_W'(old_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			ptr_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (word.last_sample) begin
					seen_q <= '0;
					ptr_q  <= '0;
				end else if (active) begin
					seen_q <= seen_nxt;
					ptr_q  <= ptr_nxt;
				end
			end
			if (!hold) begin
				valid_s1 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			item_s1.lvl    <= lvl;
			item_s1.idx    <= seen_q[INDEX_BITS-1:0];
			item_s1.start  <= INDEX_BITS'(seen_nxt - steps_x);
			item_s1.len    <= seen_nxt;
			item_s1.active <= active;
			item_s1.sub    <= sub;
			item_s1.full   <= full;
			item_s1.last   <= word.last_sample;
		end
	end

endmodule

[hw/rtl/mast_window.sv]
// window stage: running sum update, qualify test, first/last window tracking
// depends on mast_pkg; takes the delay-line read data from the ram's read register, with stage 1
`timescale 1ns / 1ps

module mast_window
	import mast_pkg::*;
#(
	parameter int TOT_W = 27,
	parameter int PROD_W = 26
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   hold,
	input  logic                   valid_s1,
	input  win_item_t              item_s1,
	input  logic [SAMPLE_BITS-1:0] old_level,
	input  logic [PROD_W-1:0]      thr_x_steps,
	output logic                   valid_s2,
	output bnd_item_t              bnd_s2
);

	logic [TOT_W-1:0]      total_q;
	logic                  first_q;
	logic [INDEX_BITS-1:0] first_end_q;
	logic                  any_q;
	logic [INDEX_BITS-1:0] last_start_q;

	logic [TOT_W-1:0]      sum;
	logic [TOT_W-1:0]      old_x;
	logic [TOT_W-1:0]      new_tot;
	logic [TOT_W-1:0]      tot_upd;
	logic                  qual;
	logic                  first_nx;
	logic [INDEX_BITS-1:0] first_end_nx;
	logic                  any_nx;
	logic [INDEX_BITS-1:0] last_start_nx;
	logic                  advance;

	always_comb begin
		sum   = total_q + TOT_W'(item_s1.lvl);
		old_x = TOT_W'(old_level);
		// sum never drops below zero
		if (item_s1.sub) begin
			new_tot = (old_x > sum) ? '0 : (sum - old_x);
		end else begin
			new_tot = sum;
		end
		tot_upd = item_s1.active ? new_tot : total_q;
		qual    = item_s1.active && item_s1.full && (new_tot >= TOT_W'(thr_x_steps));

		first_nx      = first_q || qual;
		first_end_nx  = (qual && !first_q) ? item_s1.idx : first_end_q;
		any_nx        = any_q || qual;
		last_start_nx = qual ? item_s1.start : last_start_q;
		advance       = valid_s1 && !hold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= '0;
			first_q      <= 1'b0;
			first_end_q  <= '0;
			any_q        <= 1'b0;
			last_start_q <= '0;
			valid_s2     <= 1'b0;
		end else begin
			if (advance) begin
				if (item_s1.last) begin
					total_q      <= '0;
					first_q      <= 1'b0;
					first_end_q  <= '0;
					any_q        <= 1'b0;
					last_start_q <= '0;
				end else begin
					total_q      <= tot_upd;
					first_q      <= first_nx;
					first_end_q  <= first_end_nx;
					any_q        <= any_nx;
					last_start_q <= last_start_nx;
				end
			end
			if (!hold) begin
				valid_s2 <= valid_s1 && item_s1.last;
			end
		end
	end

	// raw bounds, only meaningful on the clip's last sample
	always_ff @(posedge clk) begin
		if (!hold) begin
			bnd_s2.lb     <= first_nx ? first_end_nx : INDEX_BITS'(item_s1.len - 1'b1);
			bnd_s2.rb     <= any_nx ? last_start_nx : '0;
			bnd_s2.len_m1 <= INDEX_BITS'(item_s1.len - 1'b1);
		end
	end

endmodule

[hw/rtl/mast_bounds.sv]
// end-of-clip stage: margin widening, clamping, kept length, output register
// depends on mast_pkg; produces the stall for the whole pipeline
`timescale 1ns / 1ps

module mast_bounds
	import mast_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s2,
	input  bnd_item_t           bnd_s2,
	input  logic [MARGIN_W-1:0] margin,
	input  logic                trim_ready,
	output logic                trim_valid,
	output trim_word_t          trim_word,
	output logic                hold
);

	logic                  valid_s3;
	logic [INDEX_BITS-1:0] lb_s3;
	logic [INDEX_BITS-1:0] rb_s3;
	logic [INDEX_BITS-1:0] margin_x;
	logic [INDEX_BITS-1:0] lb_adj;
	logic [INDEX_BITS:0]   rb_sum;
	logic [INDEX_BITS-1:0] rb_adj;
	logic [INDEX_BITS:0]   kept;

	always_comb begin
		margin_x = INDEX_BITS'(margin);
		lb_adj   = (bnd_s2.lb > margin_x) ? (bnd_s2.lb - margin_x) : '0;
		rb_sum   = {1'b0, bnd_s2.rb} + {1'b0, margin_x};
		rb_adj   = (rb_sum > {1'b0, bnd_s2.len_m1}) ? bnd_s2.len_m1
			: rb_sum[INDEX_BITS-1:0];
		kept     = (rb_s3 >= lb_s3) ? ({1'b0, rb_s3} - {1'b0, lb_s3} + 1'b1) : '0;
		hold     = valid_s3 && trim_valid && !trim_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3   <= 1'b0;
			trim_valid <= 1'b0;
		end else begin
			if (!hold) begin
				valid_s3 <= valid_s2;
			end
			if (valid_s3 && !hold) begin
				trim_valid <= 1'b1;
			end else if (trim_ready) begin
				trim_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			lb_s3 <= lb_adj;
			rb_s3 <= rb_adj;
		end
		if (valid_s3 && !hold) begin
			trim_word.start_index <= lb_s3;
			trim_word.kept_length <= kept;
		end
	end

endmodule

[hw/rtl/moving_average_silence_trim.sv]
// top level of the moving-average silence trimmer
// depends on mast_pkg, mast_ram, mast_front, mast_window, mast_bounds
//
//   channel   | signals                                    | carries
//   ----------+--------------------------------------------+--------------------------------
//   sample    | sample_valid, sample_ready, sample_word    | one audio sample + end-of-clip
//   trim      | trim_valid, trim_ready, trim_word          | start index and kept length
//   cfg       | cfg_valid, cfg_ready, cfg_index, cfg_data  | register write (always ready)
//
// one sample word per cycle sustained while no stall is held; the delay-line ram does one read and one
// write per sample, and the running sum closes its loop in a single stage
// a clip's result word is built in stage 1, stage 2 and stage 3 and then loaded into the output register
// reset clears all control state; the delay line is not cleared, since a
// clip only reads entries it wrote itself
// sample_ready drops only while a finished result sits in the output register
// unread and another result is right behind it; other words keep flowing
`timescale 1ns / 1ps

module moving_average_silence_trim
	import mast_pkg::*;
#(
	parameter int MAX_WINDOW = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  sample_word_t        sample_word,
	output logic                trim_valid,
	input  logic                trim_ready,
	output trim_word_t          trim_word,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [MARGIN_W-1:0] cfg_data
);

	// widths that follow from the window depth
	localparam int ADDR_W    = $clog2(MAX_WINDOW);
	localparam int STEP_W    = $clog2(MAX_WINDOW + 1);
	localparam int TOT_W     = SAMPLE_BITS + STEP_W;
	localparam int PROD_W    = THR_W + STEP_W;
	localparam int RST_STEPS = (STEPS_RST > MAX_WINDOW) ? MAX_WINDOW : STEPS_RST;

	// configuration registers
	logic [MARGIN_W-1:0] margin_q;
	logic [STEPS_W-1:0]  steps_q;
	logic [THR_W-1:0]    thr_q;

	// derived: clamped window length (from the register directly, so a new
	// length holds for the very next word) and registered threshold * length
	logic [STEP_W-1:0]   eff_steps_c;
	logic [PROD_W-1:0]   prod_q;

	// pipeline links
	logic                   accept;
	logic                   hold;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [SAMPLE_BITS-1:0] ram_wdata;
	logic                   ram_re;
	logic [ADDR_W-1:0]      ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic                   valid_s1;
	win_item_t              item_s1;
	logic                   valid_s2;
	bnd_item_t              bnd_s2;

	assign cfg_ready    = 1'b1;
	assign sample_ready = !hold;
	assign accept       = sample_valid && sample_ready;

	// register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= '0;
			steps_q  <= STEPS_W'(STEPS_RST);
			thr_q    <= THR_W'(THR_RST);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e'(cfg_index))
				CFG_MARGIN: begin
					margin_q <= cfg_data;
				end
				CFG_WINDOW_STEPS: begin
					steps_q <= cfg_data[STEPS_W-1:0];
				end
				CFG_SILENCE_THRESHOLD: begin
					thr_q <= cfg_data[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// zero length acts as one, over-long acts as the full delay line
	always_comb begin
		if (steps_q == '0) begin
			eff_steps_c = STEP_W'(1);
		end else if (32'(steps_q) > 32'(MAX_WINDOW)) begin
			eff_steps_c = STEP_W'(MAX_WINDOW);
		end else begin
			eff_steps_c = STEP_W'(steps_q);
		end
	end

	// qualify test is sum >= threshold * length, no division needed
	// the product is registered, and the window stage tests it against stage 1 words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= PROD_W'(THR_RST * RST_STEPS);
		end else begin
			prod_q <= PROD_W'(thr_q) * PROD_W'(eff_steps_c);
		end
	end

	// delay line of levels, one entry per sample of the window
	mast_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WINDOW),
		.ADDR_W(ADDR_W)
	) u_delay_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// level, counters and ram addressing; ram read lands with stage 1
	mast_front #(
		.MAX_WINDOW(MAX_WINDOW),
		.ADDR_W    (ADDR_W),
		.STEP_W    (STEP_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.hold     (hold),
		.word     (sample_word),
		.eff_steps(eff_steps_c),
		.threshold(thr_q),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// running sum and window bookkeeping
	mast_window #(
		.TOT_W (TOT_W),
		.PROD_W(PROD_W)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold       (hold),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.old_level  (ram_rdata),
		.thr_x_steps(prod_q),
		.valid_s2   (valid_s2),
		.bnd_s2     (bnd_s2)
	);

	// margin, clamp, kept length, output register
	mast_bounds u_bounds (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.bnd_s2    (bnd_s2),
		.margin    (margin_q),
		.trim_ready(trim_ready),
		.trim_valid(trim_valid),
		.trim_word (trim_word),
		.hold      (hold)
	);

	// input stalls only behind an unread result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (trim_valid && !trim_ready))
		else $error("input stalled without a blocked result");

	// clamped window length always usable as a delay-line offset
	a_steps_range: assert property (@(posedge clk) disable iff (!arst_n)
		(eff_steps_c != '0) && (32'(eff_steps_c) <= 32'(MAX_WINDOW)))
		else $error("effective window length out of range");

	// kept span never runs past the end of the index space
	a_span_fits: assert property (@(posedge clk) disable iff (!arst_n)
		trim_valid |-> ((INDEX_BITS + 2)'(trim_word.start_index)
			+ (INDEX_BITS + 2)'(trim_word.kept_length)
			<= ((INDEX_BITS + 2)'(1) << INDEX_BITS)))
		else $error("start index plus kept length exceeds index range");

endmodule

[tb/sv/tb_moving_average_silence_trim.sv]
// self-checking testbench for moving_average_silence_trim: clips of audio words go in,
// one trim word per clip is predicted in-bench and compared field by field
// depends on mast_pkg and the moving_average_silence_trim rtl only
`timescale 1ns / 1ps

module tb_moving_average_silence_trim;
	import mast_pkg::*;

	// index 3 decodes to no register; a write there must leave every setting alone
	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int         DELAY_DEPTH = 1024;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic         sample_valid = 1'b0;
	logic         sample_ready;
	sample_word_t sample_word = '0;
	logic         trim_valid;
	logic         trim_ready = 1'b0;
	trim_word_t   trim_word;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = CFG_MARGIN;
	logic [23:0]  cfg_data = '0;

	moving_average_silence_trim u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_word  (sample_word),
		.trim_valid   (trim_valid),
		.trim_ready   (trim_ready),
		.trim_word    (trim_word),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// shadow of the register file, mirrored on every accepted cfg write
	// ------------------------------------------------------------------
	logic [23:0] cfg_margin = '0;
	logic [10:0] cfg_steps = 11'(STEPS_RST);
	logic [14:0] cfg_thr = 15'(THR_RST);

	// per-clip trimming state of the predictor
	logic [15:0] level_mem [DELAY_DEPTH];
	logic [9:0]  wr_ptr = '0;
	logic [25:0] win_sum = '0;
	logic [24:0] seen_cnt = '0;
	logic        first_hit = 1'b0;
	logic [23:0] first_end = '0;
	logic        any_hit = 1'b0;
	logic [23:0] last_start = '0;

	sample_word_t sample_backlog [$];	// words waiting for the sample driver
	trim_word_t   pending_trims [$];	// predicted trim words, oldest first

	int  errors = 0;
	int  shown = 0;
	bit  word_taken = 1'b0;		// sample handshake seen at the last rising edge
	bit  gaps_on = 1'b1;		// random idle bursts allowed on both channels
	bit  hold_go = 1'b0;		// kicks off the long receiver hold-off
	bit  trim_hold = 1'b0;
	int  send_gap = 0;
	int  take_gap = 0;

	// window length as the block uses it: zero acts as one, long values saturate
	function automatic logic [10:0] window_span();
		if (cfg_steps == 11'd0)
			return 11'd1;
		if (cfg_steps > 11'(DELAY_DEPTH))
			return 11'(DELAY_DEPTH);
		return cfg_steps;
	endfunction

	// advance the clip state by one sample word; at end of clip hand back the trim word
	function automatic void track_sample(input sample_word_t w, output bit done,
			output trim_word_t res);
		logic [15:0] raw, mag, lvl, old_lvl;
		logic [10:0] span;
		logic [9:0]  old_pos;
		logic [23:0] idx;
		logic [25:0] lb, rb, len_m1;
		done = 1'b0;
		res = '0;
		// words past the index range of a clip are dropped, their last flag still counts
		if (!seen_cnt[INDEX_BITS]) begin
			span = window_span();
			raw = w.sample;
			mag = raw[15] ? ~raw + 16'd1 : raw;
			lvl = (mag > 16'(cfg_thr)) ? mag - 16'(cfg_thr) : 16'd0;
			idx = seen_cnt[23:0];
			win_sum = win_sum + 26'(lvl);
			if (seen_cnt >= 25'(span)) begin
				// level leaving the window; span of 1024 wraps onto the write slot itself
				old_pos = wr_ptr - span[9:0];
				old_lvl = level_mem[old_pos];
				win_sum = (26'(old_lvl) > win_sum) ? 26'd0 : win_sum - 26'(old_lvl);
			end
			level_mem[wr_ptr] = lvl;
			wr_ptr = wr_ptr + 10'd1;
			seen_cnt = seen_cnt + 25'd1;
			// average >= threshold, written as sum >= threshold * span
			if (seen_cnt >= 25'(span) && win_sum >= 26'(cfg_thr) * 26'(span)) begin
				if (!first_hit) begin
					first_hit = 1'b1;
					first_end = idx;
				end
				any_hit = 1'b1;
				last_start = idx + 24'd1 - 24'(span);
			end
		end
		if (w.last_sample) begin
			len_m1 = 26'(seen_cnt) - 26'd1;
			lb = first_hit ? 26'(first_end) : len_m1;
			rb = any_hit ? 26'(last_start) : 26'd0;
			// widen by the margin, clamped to the clip
			lb = (lb > 26'(cfg_margin)) ? lb - 26'(cfg_margin) : 26'd0;
			rb = rb + 26'(cfg_margin);
			if (rb > len_m1)
				rb = len_m1;
			res.start_index = lb[23:0];
			res.kept_length = (rb >= lb) ? 25'(rb - lb + 26'd1) : 25'd0;
			done = 1'b1;
			wr_ptr = '0;
			win_sum = '0;
			seen_cnt = '0;
			first_hit = 1'b0;
			first_end = '0;
			any_hit = 1'b0;
			last_start = '0;
		end
	endfunction

	// ------------------------------------------------------------------
	// sample driver: changes inputs on the falling edge only
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		logic         nxt_valid;
		sample_word_t nxt_word;
		nxt_valid = sample_valid;
		nxt_word = sample_word;
		if (!arst_n) begin
			nxt_valid = 1'b0;
		end else if (!sample_valid || word_taken) begin
			// previous word gone (or none); pick idle or the next word
			nxt_valid = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(0, 12);
			end else if (sample_backlog.size() != 0) begin
				nxt_valid = 1'b1;
				nxt_word = sample_backlog.pop_front();
			end
		end
		sample_valid <= nxt_valid;
		sample_word <= nxt_word;
	end

	// trim receiver: random stall bursts, plus the long hold-off when asked
	always @(negedge clk) begin
		if (!arst_n || trim_hold) begin
			trim_ready <= 1'b0;
		end else if (take_gap > 0) begin
			take_gap--;
			trim_ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 7) == 0) begin
			take_gap = $urandom_range(0, 12);
			trim_ready <= 1'b0;
		end else begin
			trim_ready <= 1'b1;
		end
	end

	// long hold-off: the sender keeps going, so results pile up and the input stalls
	initial begin
		wait (hold_go);
		trim_hold = 1'b1;
		repeat (400) @(posedge clk);
		trim_hold = 1'b0;
	end

	// ------------------------------------------------------------------
	// monitor: samples both handshakes on the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		bit         got;
		trim_word_t want;
		word_taken = arst_n && sample_valid && sample_ready;
		if (arst_n && trim_valid && trim_ready) begin
			if (pending_trims.size() == 0) begin
				errors++;
				if (shown < 10)
					$display("unexpected trim word: start %0d kept %0d",
						trim_word.start_index, trim_word.kept_length);
				shown++;
			end else begin
				want = pending_trims.pop_front();
				if (want.start_index !== trim_word.start_index ||
						want.kept_length !== trim_word.kept_length) begin
					errors++;
					if (shown < 10)
						$display("trim word mismatch: expected start %0d kept %0d, got start %0d kept %0d",
							want.start_index, want.kept_length,
							trim_word.start_index, trim_word.kept_length);
					shown++;
				end
			end
		end
		if (word_taken) begin
			track_sample(sample_word, got, want);
			if (got)
				pending_trims.push_back(want);
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_MARGIN: cfg_margin = data;
			CFG_WINDOW_STEPS: cfg_steps = data[10:0];
			CFG_SILENCE_THRESHOLD: cfg_thr = data[14:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_word(input logic signed [15:0] s, input bit last);
		sample_word_t w;
		w.sample = s;
		w.last_sample = last;
		sample_backlog.push_back(w);
	endtask

	// one clip built from runs of quiet, loud and noise words
	task automatic queue_clip(input int unsigned len);
		int unsigned       left, run, kind, lim;
		logic [15:0]       mag;
		logic signed [15:0] s;
		lim = window_span() + 4;
		left = len;
		while (left > 0) begin
			run = $urandom_range(1, lim);
			if (run > left)
				run = left;
			kind = $urandom_range(0, 9);
			repeat (run) begin
				if (kind < 4)
					mag = 16'($urandom_range(0, cfg_thr));
				else
					mag = 16'($urandom_range(cfg_thr, 32767));
				if (kind >= 8)
					s = 16'($urandom);
				else if (kind >= 4 && $urandom_range(0, 15) == 0)
					s = 16'sh8000;
				else
					s = $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
				left--;
				push_word(s, left == 0);
			end
		end
	endtask

	// wait until every word is in and every trim word is out, then let the pipe drain
	task automatic settle();
		while (sample_backlog.size() != 0 || sample_valid || pending_trims.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int unsigned random_items, r, n;
		logic [23:0] m;
		logic [10:0] st;
		logic [14:0] th;
		int          k;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: window of 256 never fills, so a clip longer than one word keeps nothing
		push_word(16'sd32767, 1'b1);
		push_word(-16'sd32768, 1'b0);
		push_word(16'sd0, 1'b1);
		settle();

		// zero window acts as one, zero threshold: every window qualifies
		write_reg(CFG_MARGIN, 24'd0);
		write_reg(CFG_WINDOW_STEPS, 24'hFFF800);
		write_reg(CFG_SILENCE_THRESHOLD, 24'd0);
		write_reg(CFG_SPARE, 24'hFFFFFF);
		push_word(16'sd0, 1'b0);
		push_word(-16'sd1, 1'b0);
		push_word(16'sd1, 1'b0);
		push_word(-16'sd32768, 1'b0);
		push_word(16'sd32767, 1'b1);
		settle();

		// full-scale threshold: nothing qualifies, nothing kept
		write_reg(CFG_WINDOW_STEPS, 24'd2);
		write_reg(CFG_SILENCE_THRESHOLD, 24'd32767);
		push_word(-16'sd32768, 1'b0);
		push_word(-16'sd32768, 1'b0);
		push_word(16'sd32767, 1'b0);
		push_word(16'sd0, 1'b1);
		settle();

		// largest margin clamps to the whole clip
		write_reg(CFG_MARGIN, 24'hFFFFFF);
		write_reg(CFG_WINDOW_STEPS, 24'd3);
		write_reg(CFG_SILENCE_THRESHOLD, 24'd100);
		push_word(16'sd0, 1'b0);
		push_word(16'sd0, 1'b0);
		push_word(16'sd5000, 1'b0);
		push_word(16'sd5000, 1'b0);
		push_word(16'sd0, 1'b1);
		settle();

		// levels right around the threshold, small margin
		write_reg(CFG_MARGIN, 24'd1);
		push_word(16'sd100, 1'b0);
		push_word(16'sd101, 1'b0);
		push_word(16'sd99, 1'b0);
		push_word(-16'sd101, 1'b0);
		push_word(-16'sd100, 1'b0);
		push_word(-16'sd32768, 1'b0);
		push_word(16'sd0, 1'b0);
		push_word(16'sd0, 1'b1);
		settle();

		// back pressure: short clips while the trim side holds off
		write_reg(CFG_MARGIN, 24'd2);
		write_reg(CFG_WINDOW_STEPS, 24'd1);
		write_reg(CFG_SILENCE_THRESHOLD, 24'd1000);
		gaps_on = 1'b0;
		hold_go = 1'b1;
		repeat (30)
			queue_clip($urandom_range(1, 3));
		settle();
		gaps_on = 1'b1;

		// window register above the maximum saturates to the full delay line;
		// the clip runs past one lap of the ring
		write_reg(CFG_MARGIN, 24'd10);
		write_reg(CFG_WINDOW_STEPS, 24'd2047);
		write_reg(CFG_SILENCE_THRESHOLD, 24'd200);
		queue_clip(1030);
		settle();

		// random phases, small windows mostly; the tail runs with no idling
		random_items = 0;
		while (random_items < 100) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				m = 24'd0;
			else if (r == 1)
				m = 24'hFFFFFF;
			else if (r == 2)
				m = 24'($urandom);
			else
				m = 24'($urandom_range(0, 40));
			write_reg(CFG_MARGIN, m);
			r = $urandom_range(0, 19);
			if (r == 0)
				st = 11'd0;
			else if (r == 1)
				st = 11'($urandom_range(33, 128));
			else
				st = 11'($urandom_range(1, 32));
			write_reg(CFG_WINDOW_STEPS, {13'($urandom), st});
			r = $urandom_range(0, 9);
			if (r == 0)
				th = 15'd0;
			else if (r == 1)
				th = 15'd32767;
			else if (r == 2)
				th = 15'($urandom);
			else
				th = 15'($urandom_range(0, 3000));
			write_reg(CFG_SILENCE_THRESHOLD, {9'($urandom), th});
			gaps_on = (random_items < 60) ? ($urandom_range(0, 3) != 0) : 1'b0;
			repeat ($urandom_range(1, 3)) begin
				n = $urandom_range(1, 2 * window_span() + 16);
				queue_clip(n);
				random_items += n;
			end
			settle();
		end

		// final drain with a bound, then a few quiet cycles for stray words
		for (k = 0; k < 4000 && (sample_backlog.size() != 0 || sample_valid ||
				pending_trims.size() != 0); k++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		errors += pending_trims.size();
		if (errors == 0)
			$display("tb_moving_average_silence_trim: done, clean");
		else
			$display("tb_moving_average_silence_trim: done, errors");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#5000000;
		$display("tb_moving_average_silence_trim: done, errors");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/mast_pkg.sv
hw/rtl/mast_ram.sv
hw/rtl/mast_front.sv
hw/rtl/mast_window.sv
hw/rtl/mast_bounds.sv
hw/rtl/moving_average_silence_trim.sv
tb/sv/tb_moving_average_silence_trim.sv
